FILE: rtl/c3st_pkg.sv
// Shared types and constants of the 3D point slot table.
package c3st_pkg;

    localparam int ID_BITS = 11;

    typedef enum logic [2:0] {
        OP_GET     = 3'd0,
        OP_SET     = 3'd1,
        OP_ADD     = 3'd2,
        OP_ADDV    = 3'd3,
        OP_REMOVE  = 3'd4,
        OP_NEXT    = 3'd5,
        OP_ISDEF   = 3'd6,
        OP_UNUSED  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    localparam logic [ID_BITS-1:0] NONE_ID = 11'h7FF;

    // Datapath actions, one per cycle.
    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_RES_GET,
        ACT_RES_ISDEF,
        ACT_RES_RANGE,
        ACT_RES_FULL,
        ACT_REMOVE,
        ACT_POP,
        ACT_APPEND,
        ACT_WRITE,
        ACT_ACCUM,
        ACT_PAD,
        ACT_PAD_LAST,
        ACT_IDX_INC,
        ACT_SHIFT,
        ACT_DROP_TOP,
        ACT_SCAN_INC,
        ACT_SCAN_HIT,
        ACT_EMIT
    } act_t;

    typedef enum logic [1:0] {
        STK_TOP  = 2'd0,
        STK_IDX  = 2'd1,
        STK_NEXT = 2'd2,
        STK_RSVD = 2'd3
    } stk_rsel_t;

    typedef struct packed {
        act_t      act;
        logic      free_rd_scan;
        stk_rsel_t stk_rsel;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic in_range;
        logic next_ok;
        logic live;
        logic slot_free;
        logic stk_nonempty;
        logic not_full;
        logic used_le_id;
        logic used_eq_id;
        logic stk_hit;
        logic sh_more;
        logic scan_more;
        logic scan_free;
        logic out_free;
    } sts_t;

endpackage

FILE: rtl/c3st_ctrl.sv
// Controller state machine of the 3D point slot table.
module c3st_ctrl
    import c3st_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_READ     = 12'b0000_0000_0010,
        S_EXEC     = 12'b0000_0000_0100,
        S_PAD      = 12'b0000_0000_1000,
        S_SRCH_RD  = 12'b0000_0001_0000,
        S_SRCH_CHK = 12'b0000_0010_0000,
        S_SH_RD    = 12'b0000_0100_0000,
        S_SH_WR    = 12'b0000_1000_0000,
        S_WRITE    = 12'b0001_0000_0000,
        S_SCAN_RD  = 12'b0010_0000_0000,
        S_SCAN_CHK = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        cmd.act          = ACT_NONE;
        cmd.free_rd_scan = 1'b0;
        cmd.stk_rsel     = STK_TOP;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.act    = ACT_LOAD;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_DONE;
                case (sts.op)
                    OP_GET: begin
                        cmd.act = sts.in_range ? ACT_RES_GET : ACT_RES_RANGE;
                    end
                    OP_ISDEF: begin
                        cmd.act = sts.in_range ? ACT_RES_ISDEF : ACT_RES_RANGE;
                    end
                    OP_REMOVE: begin
                        if (!sts.in_range) begin
                            cmd.act = ACT_RES_RANGE;
                        end else if (sts.live) begin
                            cmd.act = ACT_REMOVE;
                        end
                    end
                    OP_NEXT: begin
                        if (!sts.next_ok) begin
                            cmd.act = ACT_RES_RANGE;
                        end else begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    OP_SET: begin
                        if (!sts.in_range) begin
                            cmd.act = ACT_RES_RANGE;
                        end else if (sts.used_le_id) begin
                            state_next = S_PAD;
                        end else if (sts.slot_free) begin
                            state_next = S_SRCH_RD;
                        end else begin
                            state_next = S_WRITE;
                        end
                    end
                    OP_ADD, OP_ADDV: begin
                        if (sts.op == OP_ADDV && !sts.in_range) begin
                            cmd.act = ACT_RES_RANGE;
                        end else if (sts.op == OP_ADDV && sts.live) begin
                            cmd.act = ACT_ACCUM;
                        end else if (sts.stk_nonempty) begin
                            cmd.act    = ACT_POP;
                            state_next = S_WRITE;
                        end else if (sts.not_full) begin
                            cmd.act    = ACT_APPEND;
                            state_next = S_WRITE;
                        end else begin
                            cmd.act = ACT_RES_FULL;
                        end
                    end
                    default: begin
                        cmd.act = ACT_NONE;
                    end
                endcase
            end
            S_PAD: begin
                // The target slot itself is not pushed: it would be taken back at once.
                if (sts.used_eq_id) begin
                    cmd.act    = ACT_PAD_LAST;
                    state_next = S_WRITE;
                end else begin
                    cmd.act = ACT_PAD;
                end
            end
            S_SRCH_RD: begin
                cmd.stk_rsel = STK_IDX;
                state_next   = S_SRCH_CHK;
            end
            S_SRCH_CHK: begin
                if (sts.stk_hit) begin
                    state_next = S_SH_RD;
                end else begin
                    cmd.act    = ACT_IDX_INC;
                    state_next = S_SRCH_RD;
                end
            end
            S_SH_RD: begin
                cmd.stk_rsel = STK_NEXT;
                if (sts.sh_more) begin
                    state_next = S_SH_WR;
                end else begin
                    cmd.act    = ACT_DROP_TOP;
                    state_next = S_WRITE;
                end
            end
            S_SH_WR: begin
                cmd.act    = ACT_SHIFT;
                state_next = S_SH_RD;
            end
            S_WRITE: begin
                cmd.act    = ACT_WRITE;
                state_next = S_DONE;
            end
            S_SCAN_RD: begin
                cmd.free_rd_scan = 1'b1;
                state_next       = sts.scan_more ? S_SCAN_CHK : S_DONE;
            end
            S_SCAN_CHK: begin
                cmd.free_rd_scan = 1'b1;
                if (!sts.scan_free) begin
                    cmd.act    = ACT_SCAN_HIT;
                    state_next = S_DONE;
                end else begin
                    cmd.act    = ACT_SCAN_INC;
                    state_next = S_SCAN_RD;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.act    = ACT_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/c3st_dp.sv
// Datapath of the 3D point slot table: memories, counters and result registers.
module c3st_dp
    import c3st_pkg::*;
#(
    parameter int CAPACITY    = 1024,
    parameter int COORD_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  cmd_t         cmd,
    output sts_t         sts,
    input  logic [2:0]   in_op,
    input  logic [10:0]  in_sid,
    input  logic [31:0]  in_x,
    input  logic [31:0]  in_y,
    input  logic [31:0]  in_z,
    input  logic         in_valid,
    input  logic         m_tready,
    output logic         m_tvalid,
    output logic [1:0]   out_status,
    output logic [10:0]  out_rid,
    output logic [31:0]  out_x,
    output logic [31:0]  out_y,
    output logic [31:0]  out_z,
    output logic         out_def
);

    localparam int IDW  = $clog2(CAPACITY);
    localparam int UW   = $clog2(CAPACITY + 1);
    localparam int CW   = COORD_WIDTH;
    localparam int IN_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int SW   = 3 * CW + 1;

    typedef logic signed [CW-1:0] coord_t;

    // Slot entry: defined mark on top, then z, y, x.
    logic [SW-1:0]  slot_mem [CAPACITY];
    logic           free_mem [CAPACITY];
    logic [IDW-1:0] stack_mem [CAPACITY];

    logic [SW-1:0]  slot_rdata_reg;
    logic           free_rdata_reg;
    logic [IDW-1:0] stk_rdata_reg;

    op_t            op_reg;
    logic           in_range_reg, next_ok_reg, valid_reg;
    logic [IDW-1:0] wid_reg;
    logic [UW-1:0]  scan_reg, idx_reg, used_reg, fc_reg;
    coord_t         x_reg, y_reg, z_reg;

    logic [1:0]     res_status_reg;
    logic [10:0]    res_rid_reg;
    coord_t         res_x_reg, res_y_reg, res_z_reg;
    logic           res_def_reg;
    logic           m_tvalid_reg;

    logic           sid_in_range;
    logic [IDW-1:0] free_raddr, stk_raddr;
    logic           id_lt_used;
    coord_t         slot_x, slot_y, slot_z, sum_x, sum_y, sum_z;
    logic           slot_def;

    function automatic coord_t sat_add(coord_t a, coord_t b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        if (s[CW] != s[CW-1]) begin
            sat_add = s[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            sat_add = s[CW-1:0];
        end
    endfunction

    assign sid_in_range = !in_sid[10] && ({22'd0, in_sid[9:0]} < 32'(CAPACITY));

    assign slot_x   = slot_rdata_reg[CW-1:0];
    assign slot_y   = slot_rdata_reg[2*CW-1:CW];
    assign slot_z   = slot_rdata_reg[3*CW-1:2*CW];
    assign slot_def = slot_rdata_reg[SW-1];
    assign sum_x    = sat_add(slot_x, x_reg);
    assign sum_y    = sat_add(slot_y, y_reg);
    assign sum_z    = sat_add(slot_z, z_reg);

    assign id_lt_used = UW'(wid_reg) < used_reg;
    assign free_raddr = cmd.free_rd_scan ? IDW'(scan_reg) : wid_reg;

    always_comb begin
        case (cmd.stk_rsel)
            STK_IDX:  stk_raddr = IDW'(idx_reg);
            STK_NEXT: stk_raddr = IDW'(idx_reg + UW'(1));
            default:  stk_raddr = IDW'(fc_reg - UW'(1));
        endcase
    end

    always_comb begin
        sts.op           = op_reg;
        sts.in_range     = in_range_reg;
        sts.next_ok      = next_ok_reg;
        sts.live         = in_range_reg && id_lt_used && !free_rdata_reg;
        sts.slot_free    = free_rdata_reg;
        sts.stk_nonempty = fc_reg != '0;
        sts.not_full     = used_reg < UW'(CAPACITY);
        sts.used_le_id   = used_reg <= UW'(wid_reg);
        sts.used_eq_id   = used_reg == UW'(wid_reg);
        sts.stk_hit      = stk_rdata_reg == wid_reg;
        sts.sh_more      = UW'(idx_reg + UW'(1)) < fc_reg;
        sts.scan_more    = scan_reg < used_reg;
        sts.scan_free    = free_rdata_reg;
        sts.out_free     = !m_tvalid_reg || m_tready;
    end

    // Memories: registered reads every cycle, one write port each.
    always_ff @(posedge aclk) begin
        slot_rdata_reg <= slot_mem[wid_reg];
        free_rdata_reg <= free_mem[free_raddr];
        stk_rdata_reg  <= stack_mem[stk_raddr];
        case (cmd.act)
            ACT_PAD: begin
                slot_mem[IDW'(used_reg)]  <= '0;
                free_mem[IDW'(used_reg)]  <= 1'b1;
                stack_mem[IDW'(fc_reg)]   <= IDW'(used_reg);
            end
            ACT_REMOVE: begin
                free_mem[wid_reg]        <= 1'b1;
                stack_mem[IDW'(fc_reg)]  <= wid_reg;
            end
            ACT_SHIFT: begin
                stack_mem[IDW'(idx_reg)] <= stk_rdata_reg;
            end
            ACT_WRITE: begin
                free_mem[wid_reg] <= 1'b0;
                slot_mem[wid_reg] <= valid_reg ? {1'b1, z_reg, y_reg, x_reg} : '0;
            end
            ACT_ACCUM: begin
                if (slot_def && valid_reg) begin
                    slot_mem[wid_reg] <= {1'b1, sum_z, sum_y, sum_x};
                end else begin
                    slot_mem[wid_reg] <= {1'b0, slot_z, slot_y, slot_x};
                end
            end
            default: begin
            end
        endcase
    end

    // Item registers and result registers.
    always_ff @(posedge aclk) begin
        case (cmd.act)
            ACT_LOAD: begin
                op_reg         <= op_t'(in_op);
                in_range_reg   <= sid_in_range;
                next_ok_reg    <= sid_in_range || (in_sid == NONE_ID);
                wid_reg        <= IDW'(in_sid[9:0]);
                scan_reg       <= (in_sid == NONE_ID) ? '0
                                  : UW'({22'd0, in_sid[9:0]} + 32'd1);
                idx_reg        <= '0;
                valid_reg      <= in_valid;
                x_reg          <= CW'(signed'(in_x[IN_W-1:0]));
                y_reg          <= CW'(signed'(in_y[IN_W-1:0]));
                z_reg          <= CW'(signed'(in_z[IN_W-1:0]));
                res_status_reg <= ST_OK;
                res_rid_reg    <= NONE_ID;
                res_x_reg      <= '0;
                res_y_reg      <= '0;
                res_z_reg      <= '0;
                res_def_reg    <= 1'b0;
            end
            ACT_RES_GET: begin
                if (sts.live && slot_def) begin
                    res_x_reg   <= slot_x;
                    res_y_reg   <= slot_y;
                    res_z_reg   <= slot_z;
                    res_def_reg <= 1'b1;
                end
            end
            ACT_RES_ISDEF: res_def_reg    <= id_lt_used && slot_def;
            ACT_RES_RANGE: res_status_reg <= ST_RANGE;
            ACT_RES_FULL:  res_status_reg <= ST_FULL;
            ACT_POP:       wid_reg        <= stk_rdata_reg;
            ACT_APPEND:    wid_reg        <= IDW'(used_reg);
            ACT_ACCUM:     res_rid_reg    <= 11'(wid_reg);
            ACT_WRITE: begin
                if (op_reg == OP_ADD || op_reg == OP_ADDV) begin
                    res_rid_reg <= 11'(wid_reg);
                end
            end
            ACT_IDX_INC, ACT_SHIFT: idx_reg  <= idx_reg + UW'(1);
            ACT_SCAN_INC:           scan_reg <= scan_reg + UW'(1);
            ACT_SCAN_HIT:           res_rid_reg <= 11'(scan_reg);
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            fc_reg   <= '0;
        end else begin
            case (cmd.act)
                ACT_PAD: begin
                    used_reg <= used_reg + UW'(1);
                    fc_reg   <= fc_reg + UW'(1);
                end
                ACT_PAD_LAST, ACT_APPEND: used_reg <= used_reg + UW'(1);
                ACT_REMOVE:               fc_reg   <= fc_reg + UW'(1);
                ACT_POP, ACT_DROP_TOP:    fc_reg   <= fc_reg - UW'(1);
                default: begin
                end
            endcase
        end
    end

    // Output register: a result waits here while the next item is worked on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.act == ACT_EMIT) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.act == ACT_EMIT) begin
            out_status <= res_status_reg;
            out_rid    <= res_rid_reg;
            out_x      <= 32'(res_x_reg);
            out_y      <= 32'(res_y_reg);
            out_z      <= 32'(res_z_reg);
            out_def    <= res_def_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: rtl/coord3_slot_table_unit.sv
// Top level of the 3D point slot table with free-id stack.
// One item is handled at a time. Get, is_defined, remove and an add that
// touches one slot go through accept, memory read, execute, an optional
// slot write, and loading the output register. Set past the used size first
// pads every slot from the used size up to the id. Set of a freed id
// searches the free stack for the id and closes the gap above it; next_id
// reads the slots one by one until it finds one that is not free.
// This step-by-step handling follows from the single read and write port of each memory.
// A result may wait in the output register while the next item is accepted.
module coord3_slot_table_unit
    import c3st_pkg::*;
#(
    parameter int CAPACITY    = 1024,
    parameter int COORD_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // slot_id[10:0], x_value, y_value, z_value, zero pad
    input  logic [3:0]   s_tuser,  // operation[2:0], value_valid[3]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,  // result_id[10:0], x_out, y_out, z_out, zero pad
    output logic [2:0]   m_tuser   // status[1:0], defined_out[2]
);

    cmd_t        cmd;
    sts_t        sts;
    logic [1:0]  out_status;
    logic [10:0] out_rid;
    logic [31:0] out_x, out_y, out_z;
    logic        out_def;

    c3st_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    c3st_dp #(
        .CAPACITY    (CAPACITY),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tuser[2:0]),
        .in_sid     (s_tdata[10:0]),
        .in_x       (s_tdata[42:11]),
        .in_y       (s_tdata[74:43]),
        .in_z       (s_tdata[106:75]),
        .in_valid   (s_tuser[3]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_status (out_status),
        .out_rid    (out_rid),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .out_def    (out_def)
    );

    assign m_tdata = {5'd0, out_z, out_y, out_x, out_rid};
    assign m_tuser = {out_def, out_status};

endmodule

FILE: bench/slot_table_checker.sv
// Checker for the 3D point slot table: shadow model of the table and result comparison.
module slot_table_checker
    import c3st_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic [3:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [111:0] m_tdata,
    input  logic [2:0]   m_tuser,
    output int           fail_count,
    output int           pending,
    output int           results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t     status;
        logic [10:0] rid;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        defd;
    } outcome_t;

    logic signed [31:0] xs [CAPACITY];
    logic signed [31:0] ys [CAPACITY];
    logic signed [31:0] zs [CAPACITY];
    logic               defined_mark [CAPACITY];
    logic               freed [CAPACITY];
    int                 free_ids [$];
    int                 used;
    outcome_t           expected_outcomes [$];

    function automatic logic signed [31:0] sat_sum(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [32:0] s;
        s = a + b;
        if (s > 33'sd2147483647) return 32'sh7FFFFFFF;
        if (s < -33'sd2147483648) return 32'sh80000000;
        return s[31:0];
    endfunction

    function automatic void store_point(int id, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, logic v);
        xs[id] = v ? x : '0;
        ys[id] = v ? y : '0;
        zs[id] = v ? z : '0;
        defined_mark[id] = v;
    endfunction

    // Returns the id used, or -1 when no slot is left.
    function automatic int insert_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic v);
        int id;
        if (free_ids.size() > 0) begin
            id = free_ids.pop_back();
        end else if (used < CAPACITY) begin
            id = used;
            used++;
        end else begin
            return -1;
        end
        freed[id] = 1'b0;
        store_point(id, x, y, z, v);
        return id;
    endfunction

    function automatic outcome_t predict_table_op(logic [111:0] d, logic [3:0] u);
        outcome_t o;
        op_t op;
        int sid, id, r;
        logic v, in_rng, live;
        logic [31:0] xv, yv, zv;
        op = op_t'(u[2:0]);
        v = u[3];
        sid = $signed(d[10:0]);
        xv = d[42:11];
        yv = d[74:43];
        zv = d[106:75];
        o = '0;
        o.status = ST_OK;
        o.rid = NONE_ID;
        in_rng = sid >= 0 && sid < CAPACITY;
        id = in_rng ? sid : 0;
        live = in_rng && id < used && !freed[id];
        case (op)
            OP_GET: begin
                if (!in_rng) o.status = ST_RANGE;
                else if (live && defined_mark[id]) begin
                    o.x = xs[id]; o.y = ys[id]; o.z = zs[id]; o.defd = 1'b1;
                end
            end
            OP_SET: begin
                if (!in_rng) o.status = ST_RANGE;
                else begin
                    while (used <= id) begin
                        free_ids.push_back(used);
                        freed[used] = 1'b1;
                        store_point(used, 0, 0, 0, 1'b0);
                        used++;
                    end
                    if (freed[id]) begin
                        foreach (free_ids[i]) if (free_ids[i] == id) begin
                            free_ids.delete(i);
                            break;
                        end
                        freed[id] = 1'b0;
                    end
                    store_point(id, xv, yv, zv, v);
                end
            end
            OP_ADD, OP_ADDV: begin
                if (op == OP_ADDV && !in_rng) o.status = ST_RANGE;
                else if (op == OP_ADDV && live) begin
                    if (defined_mark[id] && v) begin
                        xs[id] = sat_sum(xs[id], xv);
                        ys[id] = sat_sum(ys[id], yv);
                        zs[id] = sat_sum(zs[id], zv);
                    end else defined_mark[id] = 1'b0;
                    o.rid = id[10:0];
                end else begin
                    r = insert_point(xv, yv, zv, v);
                    if (r < 0) o.status = ST_FULL;
                    else o.rid = r[10:0];
                end
            end
            OP_REMOVE: begin
                if (!in_rng) o.status = ST_RANGE;
                else if (live) begin
                    free_ids.push_back(id);
                    freed[id] = 1'b1;
                end
            end
            OP_NEXT: begin
                if (sid < -1 || sid >= CAPACITY) o.status = ST_RANGE;
                else for (int k = sid + 1; k < used; k++) if (!freed[k]) begin
                    o.rid = k[10:0];
                    break;
                end
            end
            OP_ISDEF: begin
                if (!in_rng) o.status = ST_RANGE;
                else if (id < used && defined_mark[id]) o.defd = 1'b1;
            end
            default: ;
        endcase
        return o;
    endfunction

    always_ff @(posedge aclk) begin
        outcome_t want, got;
        if (!aresetn) begin
            used = 0;
            free_ids.delete();
            expected_outcomes.delete();
            fail_count <= 0;
            results_seen <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_outcomes.push_back(predict_table_op(s_tdata, s_tuser));
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                got.status = status_t'(m_tuser[1:0]);
                got.defd = m_tuser[2];
                got.rid = m_tdata[10:0];
                got.x = m_tdata[42:11];
                got.y = m_tdata[74:43];
                got.z = m_tdata[106:75];
                if (expected_outcomes.size() == 0) begin
                    $display("%0t: result with nothing expected: %p", $realtime, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got != want || m_tdata[111:107] != 0) begin
                        $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending <= expected_outcomes.size();
    end
endmodule

FILE: bench/testbench.sv
// Top of the slot table bench: clock, reset, stimulus, flow control and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import c3st_pkg::*;

    localparam int CAP = 1024;
    localparam int CYCLE_LIMIT = 15_000_000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [2:0]   m_tuser;
    int           fail_count, pending, results_seen;
    int           send_idle_pct = 12, recv_idle_pct = 82;
    int           hold_cycles = 0;
    logic         stall_start = 1'b0;
    logic         stall_taken = 1'b0;
    int           cycle_count = 0;
    int           live_hint = 0;

    coord3_slot_table_unit dut (.*);

    slot_table_checker #(.CAPACITY(CAP)) checker_i (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("coord3_slot_table_unit verification failed");
            $finish;
        end
    end

    // Receiver flow control; a nonzero hold count keeps tready low while it counts down.
    always @(posedge aclk) begin
        if (stall_start && !stall_taken) begin
            stall_taken <= 1'b1;
            hold_cycles <= 300;
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_op(op_t op, int sid, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic v);
        logic [10:0] id_bits;
        id_bits = sid[10:0];
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, z, y, x, id_bits};
        s_tuser <= {v, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(3) - 2;
            default: return $urandom;
        endcase
    endfunction

    // Ids mostly land in the low range, so slots are reused and revisited.
    function automatic int pick_id();
        case ($urandom_range(19))
            0: return -1 - $urandom_range(1023);
            1: return CAP + $urandom_range(1023 - 0) % 1024;
            2: return $urandom_range(CAP - 1);
            default: return $urandom_range(live_hint + 4);
        endcase
    endfunction

    task automatic random_ops(int count);
        op_t op;
        for (int i = 0; i < count; i++) begin
            op = op_t'($urandom_range(7));
            if (op == OP_UNUSED && $urandom_range(3) != 0) op = OP_ADD;
            send_op(op, (op == OP_NEXT && $urandom_range(3) == 0) ? -1 : pick_id(),
                    pick_coord(), pick_coord(), pick_coord(), $urandom_range(7) != 0);
            if (op == OP_SET || op == OP_ADD) live_hint = (live_hint < 60) ? live_hint + 1 : 60;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0 || (s_tvalid && !s_tready)) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every operation, range edges, saturation, undefined values.
        send_op(OP_GET, 0, 0, 0, 0, 1);
        send_op(OP_ISDEF, 5, 0, 0, 0, 1);
        send_op(OP_NEXT, -1, 0, 0, 0, 1);
        send_op(OP_ADD, 0, 32'h7FFFFFF0, 32'h80000010, 32'h1, 1);
        send_op(OP_ADDV, 0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1);
        send_op(OP_GET, 0, 0, 0, 0, 1);
        send_op(OP_SET, 6, 32'hFFFFFFFF, 32'h12345678, 32'h80000000, 1);
        send_op(OP_ISDEF, 3, 0, 0, 0, 1);
        send_op(OP_GET, 3, 0, 0, 0, 1);
        send_op(OP_NEXT, 0, 0, 0, 0, 1);
        send_op(OP_SET, 2, 32'h5, 32'h6, 32'h7, 0);
        send_op(OP_ADDV, 2, 32'h1, 32'h1, 32'h1, 1);
        send_op(OP_ADDV, 4, 32'h1, 32'h1, 32'h1, 1);
        send_op(OP_REMOVE, 6, 0, 0, 0, 1);
        send_op(OP_REMOVE, 6, 0, 0, 0, 1);
        send_op(OP_REMOVE, 900, 0, 0, 0, 1);
        send_op(OP_ISDEF, 6, 0, 0, 0, 1);
        send_op(OP_ADD, 0, 32'h1, 32'h2, 32'h3, 1);
        send_op(OP_GET, -1, 0, 0, 0, 1);
        send_op(OP_SET, CAP, 0, 0, 0, 1);
        send_op(OP_NEXT, -2, 0, 0, 0, 1);
        send_op(OP_NEXT, CAP - 1, 0, 0, 0, 1);
        send_op(OP_ADDV, -1024, 0, 0, 0, 1);
        send_op(OP_UNUSED, 3, 32'hFFFFFFFF, 0, 0, 1);
        live_hint = 8;
        drain();

        random_ops(100);
        drain();

        // Long receiver stall while the sender keeps offering transfers.
        stall_start <= 1'b1;
        send_idle_pct = 82;
        recv_idle_pct = 12;
        random_ops(100);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_ops(80);
        // Fill the table to capacity so the full status shows up, then go past it.
        send_op(OP_SET, CAP - 1, 32'h1, 32'h2, 32'h3, 1);
        for (int i = 0; i < CAP + 3; i++)
            send_op(OP_ADD, 0, $urandom, $urandom, $urandom, 1);
        send_op(OP_ADDV, CAP - 1, 32'h7FFFFFFF, 32'h80000000, 32'h0, 1);
        send_op(OP_GET, CAP - 1, 0, 0, 0, 1);
        send_op(OP_REMOVE, 17, 0, 0, 0, 1);
        send_op(OP_ADD, 0, 32'h9, 32'h9, 32'h9, 1);
        send_op(OP_ADD, 0, 32'h9, 32'h9, 32'h9, 1);
        random_ops(15);
        drain();

        $display("Covered all seven operations plus the unused code, range errors, padding sets,");
        $display("free-id reuse, saturating adds, a full table and %0d results.", results_seen);
        if (fail_count == 0) begin
            $display("coord3_slot_table_unit verification clean");
        end else begin
            $display("coord3_slot_table_unit verification failed");
        end
        $finish;
    end
endmodule

FILE: coord3_slot_table_unit.f
rtl/c3st_pkg.sv
rtl/c3st_ctrl.sv
rtl/c3st_dp.sv
rtl/coord3_slot_table_unit.sv
bench/slot_table_checker.sv
bench/testbench.sv
